[rtl/core/aabb_pkg.sv]
`default_nettype none

package aabb_pkg;

	// coordinate width, signed Q16.16
	localparam int unsigned CoordW = 32;

	// normal axis codes
	localparam logic [1:0] AXIS_X = 2'd0;
	localparam logic [1:0] AXIS_Y = 2'd1;
	localparam logic [1:0] AXIS_Z = 2'd2;

	// one box pair request
	typedef struct packed {
		logic signed [CoordW-1:0] a_min_x;
		logic signed [CoordW-1:0] a_min_y;
		logic signed [CoordW-1:0] a_min_z;
		logic signed [CoordW-1:0] a_max_x;
		logic signed [CoordW-1:0] a_max_y;
		logic signed [CoordW-1:0] a_max_z;
		logic signed [CoordW-1:0] b_min_x;
		logic signed [CoordW-1:0] b_min_y;
		logic signed [CoordW-1:0] b_min_z;
		logic signed [CoordW-1:0] b_max_x;
		logic signed [CoordW-1:0] b_max_y;
		logic signed [CoordW-1:0] b_max_z;
	} req_t;

	// one contact result
	typedef struct packed {
		logic                     hit;
		logic [CoordW-1:0]        depth;
		logic [1:0]               normal_axis;
		logic                     normal_negative;
		logic signed [CoordW-1:0] contact_x;
		logic signed [CoordW-1:0] contact_y;
		logic signed [CoordW-1:0] contact_z;
	} result_t;

	// per-axis terms handed from an axis unit to the select stage
	typedef struct packed {
		logic                     hit;   // strict overlap on this axis
		logic signed [CoordW:0]   ov;    // signed overlap length
		logic                     neg;   // A centre below B centre
		logic signed [CoordW-1:0] face;  // A face used if this is the normal axis
		logic signed [CoordW-1:0] mid;   // floor midpoint of the overlap interval
	} axis_info_t;

endpackage

`default_nettype wire

[rtl/core/aabb_pair_contact_detect.sv]
`default_nettype none

// Channel   Ports                Direction  Accepted at
// request   start, busy, req     in         rising edge with start high, busy low
// result    done, result         out        rising edge ending the cycle done is high
//
// One request per cycle; busy is always low. A request passes the bounds stage,
// the overlap stage and the axis select stage; done rises with the result out of
// the last, and the result is taken at the rising edge that ends that cycle.
// Reset clears only the valid bits travelling with the data.
// The receiver cannot stall, so the pipeline never holds.
module aabb_pair_contact_detect (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	output logic                  busy,
	input  wire aabb_pkg::req_t   req,
	output logic                  done,
	output aabb_pkg::result_t     result
);

	logic v_s1, v_s2;
	aabb_pkg::axis_info_t info_x, info_y, info_z;

	assign busy = 1'b0;

	// valid bits alongside the axis units
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= start & ~busy;
			v_s2 <= v_s1;
		end
	end

	aabb_axis u_axis_x (
		.clk   (clk),
		.a_min (req.a_min_x),
		.a_max (req.a_max_x),
		.b_min (req.b_min_x),
		.b_max (req.b_max_x),
		.info  (info_x)
	);

	aabb_axis u_axis_y (
		.clk   (clk),
		.a_min (req.a_min_y),
		.a_max (req.a_max_y),
		.b_min (req.b_min_y),
		.b_max (req.b_max_y),
		.info  (info_y)
	);

	aabb_axis u_axis_z (
		.clk   (clk),
		.a_min (req.a_min_z),
		.a_max (req.a_max_z),
		.b_min (req.b_min_z),
		.b_max (req.b_max_z),
		.info  (info_z)
	);

	aabb_select u_select (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_in (v_s2),
		.info_x   (info_x),
		.info_y   (info_y),
		.info_z   (info_z),
		.done     (done),
		.result   (result)
	);

endmodule

`default_nettype wire

[rtl/core/aabb_axis.sv]
`default_nettype none

// Two-stage per-axis unit: interval bounds and centre sums, then overlap,
// midpoint and centre compare.
module aabb_axis (
	input  wire logic                                 clk,
	input  wire logic signed [aabb_pkg::CoordW-1:0]   a_min,
	input  wire logic signed [aabb_pkg::CoordW-1:0]   a_max,
	input  wire logic signed [aabb_pkg::CoordW-1:0]   b_min,
	input  wire logic signed [aabb_pkg::CoordW-1:0]   b_max,
	output aabb_pkg::axis_info_t                      info
);

	localparam int unsigned W = aabb_pkg::CoordW;

	logic signed [W-1:0] lo_s1, hi_s1, amin_s1, amax_s1;
	logic signed [W:0]   sa_s1, sb_s1;
	logic                hit_s1;
	aabb_pkg::axis_info_t info_s2;

	// stage 1: overlap interval bounds, strict test, centre sums
	always_ff @(posedge clk) begin
		lo_s1   <= (a_max < b_max) ? a_max : b_max;
		hi_s1   <= (a_min > b_min) ? a_min : b_min;
		hit_s1  <= (a_min < b_max) && (b_min < a_max);
		sa_s1   <= {a_min[W-1], a_min} + {a_max[W-1], a_max};
		sb_s1   <= {b_min[W-1], b_min} + {b_max[W-1], b_max};
		amin_s1 <= a_min;
		amax_s1 <= a_max;
	end

	// stage 2: overlap, midpoint, centre compare and face choice
	logic signed [W:0] mid_sum;
	assign mid_sum = {hi_s1[W-1], hi_s1} + {lo_s1[W-1], lo_s1};

	always_ff @(posedge clk) begin
		info_s2.hit  <= hit_s1;
		info_s2.ov   <= {lo_s1[W-1], lo_s1} - {hi_s1[W-1], hi_s1};
		info_s2.neg  <= sa_s1 < sb_s1;
		info_s2.face <= (sa_s1 > sb_s1) ? amin_s1 : amax_s1;
		info_s2.mid  <= mid_sum[W:1];
	end

	assign info = info_s2;

endmodule

`default_nettype wire

[rtl/core/aabb_select.sv]
`default_nettype none

// Output stage: least-penetration axis, depth clamp, contact point assembly.
module aabb_select (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  valid_in,
	input  wire aabb_pkg::axis_info_t  info_x,
	input  wire aabb_pkg::axis_info_t  info_y,
	input  wire aabb_pkg::axis_info_t  info_z,
	output logic                       done,
	output aabb_pkg::result_t          result
);

	localparam int unsigned W = aabb_pkg::CoordW;

	logic                 done_s3;
	aabb_pkg::result_t    res_s3;
	aabb_pkg::result_t    res_d;
	aabb_pkg::axis_info_t sel;
	logic [1:0]           ax;
	logic                 hit_all;

	// axis choice, ties go to x then y
	always_comb begin
		priority if (info_x.ov <= info_y.ov && info_x.ov <= info_z.ov) begin
			ax  = aabb_pkg::AXIS_X;
			sel = info_x;
		end else if (info_y.ov <= info_z.ov) begin
			ax  = aabb_pkg::AXIS_Y;
			sel = info_y;
		end else begin
			ax  = aabb_pkg::AXIS_Z;
			sel = info_z;
		end
	end

	assign hit_all = info_x.hit & info_y.hit & info_z.hit;

	// result word, all zero on a miss
	always_comb begin
		res_d = '0;
		if (hit_all) begin
			res_d.hit             = 1'b1;
			res_d.depth           = (sel.ov > 0) ? sel.ov[W-1:0] : '0;
			res_d.normal_axis     = ax;
			res_d.normal_negative = sel.neg;
			res_d.contact_x = (ax == aabb_pkg::AXIS_X) ? info_x.face : info_x.mid;
			res_d.contact_y = (ax == aabb_pkg::AXIS_Y) ? info_y.face : info_y.mid;
			res_d.contact_z = (ax == aabb_pkg::AXIS_Z) ? info_z.face : info_z.mid;
		end
	end

	// strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s3 <= 1'b0;
		end else begin
			done_s3 <= valid_in;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		res_s3 <= res_d;
	end

	assign done   = done_s3;
	assign result = res_s3;

endmodule

`default_nettype wire

[bench/tb.sv]
`timescale 1ns / 1ps

module tb;

	localparam int LIMIT     = 200000;  // cycles before the run is abandoned
	localparam int N_RANDOM  = 900;
	localparam int DRAIN_AT  = 450;     // hold off here until the pipe is empty
	localparam int TAIL      = 120;     // last requests go out back to back
	localparam int SETTLE    = 8;       // cycles after the last result

	localparam logic signed [31:0] MINC = 32'sh8000_0000;
	localparam logic signed [31:0] MAXC = 32'sh7fff_ffff;
	localparam logic signed [31:0] ONE  = 32'sh0001_0000;

	// per-axis span shapes for generated pairs
	localparam int SPAN_WIDE    = 0;
	localparam int SPAN_NEAR    = 1;
	localparam int SPAN_CENTRED = 2;
	localparam int SPAN_TOUCH   = 3;
	localparam int SPAN_INVERT  = 4;
	localparam int SPAN_NOISE   = 5;

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    start = 1'b0;
	aabb_pkg::req_t    req = '0;
	logic    busy;
	logic    done;
	aabb_pkg::result_t result;

	aabb_pkg::req_t    pair_q[$];
	aabb_pkg::result_t contact_q[$];
	int      outstanding = 0;
	int      fail_cnt = 0;
	int      cycles = 0;

	// driver bookkeeping
	int      sent;
	int      gap_left;
	bit      hold_off;
	bit      took;
	bit      go;

	aabb_pair_contact_detect u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.req    (req),
		.done   (done),
		.result (result)
	);

	always #10 clk = ~clk;

	// expected contact for one box pair
	function automatic aabb_pkg::result_t contact_of(input aabb_pkg::req_t r);
		longint  amin[3], amax[3], bmin[3], bmax[3], ov[3];
		longint  sa, sb, s, f;
		logic [31:0] pt[3];
		int      axi;
		bit      overlap;
		aabb_pkg::result_t o;
		amin[0] = longint'(r.a_min_x); amin[1] = longint'(r.a_min_y);
		amin[2] = longint'(r.a_min_z);
		amax[0] = longint'(r.a_max_x); amax[1] = longint'(r.a_max_y);
		amax[2] = longint'(r.a_max_z);
		bmin[0] = longint'(r.b_min_x); bmin[1] = longint'(r.b_min_y);
		bmin[2] = longint'(r.b_min_z);
		bmax[0] = longint'(r.b_max_x); bmax[1] = longint'(r.b_max_y);
		bmax[2] = longint'(r.b_max_z);
		o = '0;
		overlap = 1'b1;
		for (int k = 0; k < 3; k++)
			if (!(amin[k] < bmax[k] && bmin[k] < amax[k]))
				overlap = 1'b0;
		if (!overlap)
			return o;
		for (int k = 0; k < 3; k++)
			ov[k] = ((amax[k] < bmax[k]) ? amax[k] : bmax[k])
				- ((amin[k] > bmin[k]) ? amin[k] : bmin[k]);
		// least overlap, ties to x then y
		if (ov[0] <= ov[1] && ov[0] <= ov[2])
			axi = 0;
		else if (ov[1] <= ov[2])
			axi = 1;
		else
			axi = 2;
		sa = amin[axi] + amax[axi];
		sb = bmin[axi] + bmax[axi];
		for (int k = 0; k < 3; k++) begin
			if (k == axi) begin
				f = (sa > sb) ? amin[k] : amax[k];
				pt[k] = 32'(f);
			end else begin
				s = ((amin[k] > bmin[k]) ? amin[k] : bmin[k])
					+ ((amax[k] < bmax[k]) ? amax[k] : bmax[k]);
				pt[k] = 32'(s >>> 1);
			end
		end
		o.hit = 1'b1;
		o.depth = (ov[axi] > 0) ? 32'(ov[axi]) : 32'd0;
		case (axi)
			0: o.normal_axis = aabb_pkg::AXIS_X;
			1: o.normal_axis = aabb_pkg::AXIS_Y;
			default: o.normal_axis = aabb_pkg::AXIS_Z;
		endcase
		o.normal_negative = (sa < sb);
		o.contact_x = pt[0];
		o.contact_y = pt[1];
		o.contact_z = pt[2];
		return o;
	endfunction

	function automatic aabb_pkg::req_t box_pair(
		input logic signed [31:0] xa0, xa1, xb0, xb1,
		input logic signed [31:0] ya0, ya1, yb0, yb1,
		input logic signed [31:0] za0, za1, zb0, zb1);
		aabb_pkg::req_t r;
		r.a_min_x = xa0; r.a_max_x = xa1; r.b_min_x = xb0; r.b_max_x = xb1;
		r.a_min_y = ya0; r.a_max_y = ya1; r.b_min_y = yb0; r.b_max_y = yb1;
		r.a_min_z = za0; r.a_max_z = za1; r.b_min_z = zb0; r.b_max_z = zb1;
		return r;
	endfunction

	// one axis worth of bounds: a = [a0, a1], b = [b0, b1]
	task automatic make_span(input int mode, output int a0, a1, b0, b1);
		int v[4];
		int c, w, h, t;
		c = int'($urandom) >>> 2;
		w = $urandom_range(1, 1 << 20);
		h = $urandom_range(1, 1 << 20);
		for (int i = 0; i < 4; i++)
			v[i] = (mode == SPAN_WIDE || mode == SPAN_NOISE) ? int'($urandom)
				: c + int'($urandom_range(0, 1 << 20));
		if (mode == SPAN_NOISE) begin
			a0 = v[0]; a1 = v[1]; b0 = v[2]; b1 = v[3];
			return;
		end
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3 - i; j++)
				if (v[j] > v[j+1]) begin
					t = v[j]; v[j] = v[j+1]; v[j+1] = t;
				end
		case (mode)
			SPAN_CENTRED: begin
				a0 = c - w; a1 = c + w; b0 = c - h; b1 = c + h;
			end
			SPAN_TOUCH: begin
				if ($urandom_range(0, 1)) begin
					a0 = c - w; a1 = c; b0 = c; b1 = c + h;
				end else begin
					a0 = c; a1 = c + w; b0 = c - h; b1 = c;
				end
			end
			SPAN_INVERT: begin
				// inverted box still passes the strict test
				if ($urandom_range(0, 1)) begin
					a0 = v[2]; a1 = v[1]; b0 = v[0]; b1 = v[3];
				end else begin
					a0 = v[0]; a1 = v[3]; b0 = v[2]; b1 = v[1];
				end
			end
			default: begin
				case ($urandom_range(0, 3))
					0: begin a0 = v[0]; a1 = v[2]; b0 = v[1]; b1 = v[3]; end
					1: begin a0 = v[1]; a1 = v[3]; b0 = v[0]; b1 = v[2]; end
					2: begin a0 = v[0]; a1 = v[3]; b0 = v[1]; b1 = v[2]; end
					default: begin a0 = v[1]; a1 = v[2]; b0 = v[0]; b1 = v[3]; end
				endcase
			end
		endcase
	endtask

	task automatic add_random_pair();
		int s[3][4];
		int mode[3];
		int pick, odd;
		pick = $urandom_range(0, 99);
		odd = $urandom_range(0, 2);
		for (int k = 0; k < 3; k++) begin
			case ($urandom_range(0, 5))
				0: mode[k] = SPAN_WIDE;
				1: mode[k] = SPAN_CENTRED;
				default: mode[k] = SPAN_NEAR;
			endcase
			if (pick >= 70 && pick < 82 && k == odd)
				mode[k] = SPAN_TOUCH;
			else if (pick >= 82 && pick < 92 && k == odd)
				mode[k] = SPAN_INVERT;
			else if (pick >= 92)
				mode[k] = SPAN_NOISE;
			make_span(mode[k], s[k][0], s[k][1], s[k][2], s[k][3]);
		end
		// equal overlaps on several axes exercise the tie order
		if ($urandom_range(0, 7) == 0) begin
			s[1] = s[0];
			if ($urandom_range(0, 1))
				s[2] = s[0];
		end else if ($urandom_range(0, 9) == 0) begin
			s[2] = s[1];
		end
		pair_q.push_back(box_pair(s[0][0], s[0][1], s[0][2], s[0][3],
			s[1][0], s[1][1], s[1][2], s[1][3],
			s[2][0], s[2][1], s[2][2], s[2][3]));
	endtask

	task automatic report_mismatch(input string what, input logic [31:0] want, got);
		$display("ERROR @%0t %s: expected %h, got %h", $realtime, what, want, got);
		fail_cnt++;
	endtask

	task automatic compare_contact(input aabb_pkg::result_t want,
		input aabb_pkg::result_t got);
		if (got.hit !== want.hit)
			report_mismatch("hit", 32'(want.hit), 32'(got.hit));
		if (got.depth !== want.depth)
			report_mismatch("depth", want.depth, got.depth);
		if (got.normal_axis !== want.normal_axis)
			report_mismatch("normal_axis", 32'(want.normal_axis), 32'(got.normal_axis));
		if (got.normal_negative !== want.normal_negative)
			report_mismatch("normal_negative", 32'(want.normal_negative),
				32'(got.normal_negative));
		if (got.contact_x !== want.contact_x)
			report_mismatch("contact_x", want.contact_x, got.contact_x);
		if (got.contact_y !== want.contact_y)
			report_mismatch("contact_y", want.contact_y, got.contact_y);
		if (got.contact_z !== want.contact_z)
			report_mismatch("contact_z", want.contact_z, got.contact_z);
	endtask

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			req <= '0;
			sent = 0;
			gap_left = 0;
			hold_off = 1'b0;
		end else begin
			took = start && !busy;
			if (took)
				sent++;
			if (hold_off && outstanding == 0)
				hold_off = 1'b0;
			if (took && sent == DRAIN_AT)
				hold_off = 1'b1;
			if (start && !took)
				go = 1'b1;
			else if (pair_q.size() == 0 || hold_off)
				go = 1'b0;
			else if (gap_left > 0) begin
				gap_left--;
				go = 1'b0;
			end else if (pair_q.size() > TAIL && $urandom_range(0, 5) == 0) begin
				gap_left = $urandom_range(0, 3);
				go = 1'b0;
			end else
				go = 1'b1;
			if (go && !(start && !took))
				req <= pair_q.pop_front();
			start <= go;
		end
	end

	// result monitor: check, then log the request accepted at this edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			outstanding <= 0;
		end else begin
			if (done) begin
				if (contact_q.size() == 0)
					report_mismatch("result with no request pending", '0, result.depth);
				else
					compare_contact(contact_q.pop_front(), result);
			end
			if (start && !busy)
				contact_q.push_back(contact_of(req));
			outstanding <= contact_q.size();
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles >= LIMIT) begin
			$display("aabb_pair_contact_detect: mismatch");
			$finish;
		end
	end

	initial begin
		// all zero: touching everywhere, a miss
		pair_q.push_back(box_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		// identical unit boxes: three-way tie, equal centres
		pair_q.push_back(box_pair(0, ONE, 0, ONE, 0, ONE, 0, ONE, 0, ONE, 0, ONE));
		// both boxes span the whole range
		pair_q.push_back(box_pair(MINC, MAXC, MINC, MAXC, MINC, MAXC, MINC, MAXC,
			MINC, MAXC, MINC, MAXC));
		// small B inside a full-range A
		pair_q.push_back(box_pair(MINC, MAXC, -ONE, ONE, MINC, MAXC, -ONE, 2 * ONE,
			MINC, MAXC, -3 * ONE, ONE));
		// touching faces on x, then on z from the other side
		pair_q.push_back(box_pair(0, ONE, ONE, 2 * ONE, 0, ONE, 0, ONE, 0, ONE, 0, ONE));
		pair_q.push_back(box_pair(0, ONE, 0, ONE, 0, ONE, 0, ONE, ONE, 2 * ONE, 0, ONE));
		// y least, A below B
		pair_q.push_back(box_pair(0, 4 * ONE, 0, 4 * ONE, 0, 4 * ONE, 3 * ONE, 5 * ONE,
			0, 4 * ONE, 0, 4 * ONE));
		// z least, A above B
		pair_q.push_back(box_pair(0, 4 * ONE, 0, 4 * ONE, 0, 4 * ONE, 0, 4 * ONE,
			3 * ONE, 5 * ONE, 0, 4 * ONE));
		// x least, A below B
		pair_q.push_back(box_pair(-5 * ONE, -ONE, -2 * ONE, 3 * ONE, 0, 9 * ONE, 1, 8 * ONE,
			-7, 7 * ONE, -3, 6 * ONE));
		// tie between y and z, both below x
		pair_q.push_back(box_pair(0, 4 * ONE, 0, 4 * ONE, 0, 4 * ONE, 3 * ONE, 5 * ONE,
			0, 4 * ONE, 3 * ONE, 5 * ONE));
		// inverted A on x still passes, negative overlap clamps to zero depth
		pair_q.push_back(box_pair(2 * ONE, ONE, 0, 3 * ONE, 0, 4 * ONE, 0, 4 * ONE,
			0, 4 * ONE, 0, 4 * ONE));
		// inverted B on y
		pair_q.push_back(box_pair(0, 4 * ONE, 0, 4 * ONE, 0, 3 * ONE, 2 * ONE, ONE,
			0, 4 * ONE, 0, 4 * ONE));
		// B disjoint from A on x, which fails the strict test
		pair_q.push_back(box_pair(0, ONE, 2 * ONE, 3 * ONE, 0, ONE, 0, ONE, 0, ONE, 0, ONE));
		// corners of the coordinate range
		pair_q.push_back(box_pair(MINC, MINC + 1, MINC, MAXC, MAXC - 1, MAXC, MINC, MAXC,
			MINC, MAXC, MAXC - 1, MAXC));
		pair_q.push_back(box_pair(MINC, MAXC, MAXC - 2, MAXC, MINC, MAXC, MINC, MINC + 3,
			MINC, MAXC, MINC, MAXC));
		// odd negative midpoints round toward minus infinity
		pair_q.push_back(box_pair(-3, 5, -1, 7, -5, -1, -4, 10, -9, 100, -40, -2));
		// equal centres with different sizes
		pair_q.push_back(box_pair(-ONE, ONE, -3, 3, -2 * ONE, 2 * ONE, -ONE, ONE,
			-ONE, ONE, -ONE, ONE));
		for (int i = 0; i < N_RANDOM; i++)
			add_random_pair();

		repeat (12) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (pair_q.size() != 0 || start || outstanding != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (contact_q.size() != 0)
			report_mismatch("results never delivered", contact_q.size(), 0);
		if (fail_cnt == 0) begin
			$display("aabb_pair_contact_detect: match");
		end else begin
			$display("aabb_pair_contact_detect: mismatch");
		end
		$finish;
	end

endmodule
